// File: hw/rtl/oil_dose_scheduler_defines.svh
// ----------------------------------------------------------------------------
// oil dose scheduler assertion macros
// shared property forms for the checker, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef OIL_DOSE_SCHEDULER_DEFINES_SVH
`define OIL_DOSE_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define ODS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ods_pkg.sv
// ----------------------------------------------------------------------------
// ods_pkg
// shared widths, constants and register codes of the oil dose scheduler
// ----------------------------------------------------------------------------
package ods_pkg;

  // default sizing
  localparam int unsigned SAMPLES_PER_READING_DEF = 10;
  localparam int unsigned ADC_BITS_DEF            = 12;

  // field widths
  localparam int unsigned LEVEL_W   = 7;
  localparam int unsigned DOSE_W    = 16;
  localparam int unsigned TIMER_W   = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // sensor calibration: raw reading at empty and at full, full scale percent
  localparam int unsigned LVL_EMPTY_RAW = 4000;
  localparam int unsigned LVL_FULL_RAW  = 1500;
  localparam int unsigned LVL_FULL_PCT  = 100;
  // raw counts per percent, the calibration span divides evenly
  localparam int unsigned LVL_RAW_PER_PCT = (LVL_EMPTY_RAW - LVL_FULL_RAW) / LVL_FULL_PCT;

  // register reset values
  localparam logic [15:0] DOSE_TICKS_RST      = 16'd3000;
  localparam logic [31:0] INTERVAL_TICKS_RST  = 32'd3600000;
  localparam logic [6:0]  LOW_THRESHOLD_RST   = 7'd20;
  localparam logic [6:0]  EMPTY_THRESHOLD_RST = 7'd5;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOSE_TICKS      = 2'd0,
    CFG_INTERVAL_TICKS  = 2'd1,
    CFG_LOW_THRESHOLD   = 2'd2,
    CFG_EMPTY_THRESHOLD = 2'd3
  } cfg_reg_e;

  // result of one level evaluation
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               alert;
    logic               skip;
  } level_res_t;

endpackage

// File: hw/rtl/ods_level.sv
// ----------------------------------------------------------------------------
// ods_level
// maps a finished sample sum to a clamped percent level and threshold flags
// ----------------------------------------------------------------------------
module ods_level #(
  parameter int unsigned SAMPLES_PER_READING = ods_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned SUM_W               = 16
) (
  input  logic [SUM_W-1:0]            sum_i,
  input  logic [ods_pkg::LEVEL_W-1:0] low_threshold_i,
  input  logic [ods_pkg::LEVEL_W-1:0] empty_threshold_i,
  output ods_pkg::level_res_t         res_o
);

  // level = (empty - floor(sum/n)) / span folds into one divide:
  // floor((empty*n - sum + n - 1) / (span*n)) for sum below empty*n
  localparam int unsigned EmptySum = ods_pkg::LVL_EMPTY_RAW * SAMPLES_PER_READING;
  localparam int unsigned NumTop   = EmptySum + SAMPLES_PER_READING - 1;
  localparam int unsigned NumW     = $clog2(NumTop + 1);
  localparam int unsigned CalcW    = (SUM_W > NumW) ? SUM_W : NumW;
  localparam int unsigned DivLevel = ods_pkg::LVL_RAW_PER_PCT * SAMPLES_PER_READING;

  // divide by the constant as a multiply by its rounded-up reciprocal; the
  // rounding error times any numerator stays below one unit of the shift,
  // so the quotient is exact
  localparam int unsigned     RecipSh = CalcW + $clog2(DivLevel);
  localparam longint unsigned Recip   = ((64'd1 << RecipSh) + DivLevel - 1) / DivLevel;
  localparam int unsigned     RecipW  = $clog2(Recip + 1);
  localparam int unsigned     ProdW   = CalcW + RecipW;

  logic [CalcW-1:0]            sum_ext;
  logic                        is_empty;
  logic [CalcW-1:0]            num;
  logic [ProdW-1:0]            prod;
  logic [CalcW-1:0]            quot;
  logic [ods_pkg::LEVEL_W-1:0] level;

  assign sum_ext  = CalcW'(sum_i);
  assign is_empty = sum_ext >= CalcW'(EmptySum);
  assign num      = CalcW'(NumTop) - sum_ext;
  assign prod     = ProdW'(num) * ProdW'(Recip);
  assign quot     = CalcW'(prod >> RecipSh);

  // clamp to full scale, zero at or past the empty reading
  always_comb begin
    if (is_empty) begin
      level = '0;
    end else if (quot > CalcW'(ods_pkg::LVL_FULL_PCT)) begin
      level = ods_pkg::LEVEL_W'(ods_pkg::LVL_FULL_PCT);
    end else begin
      level = quot[ods_pkg::LEVEL_W-1:0];
    end
  end

  // threshold flags
  assign res_o.level = level;
  assign res_o.alert = level < low_threshold_i;
  assign res_o.skip  = level < empty_threshold_i;

endmodule

// File: hw/rtl/oil_dose_scheduler.sv
// ----------------------------------------------------------------------------
// oil_dose_scheduler
// measure, dose and wait sequencer for an oil atomizer fed by samples and ticks
// ----------------------------------------------------------------------------
// Each input word is an ADC sample or a 1 ms tick; every accepted word yields
// exactly one result word holding the atomizer drive, the last level, the
// low-oil alert, the dose count and a flag marking the sample that finished a
// reading. The block takes one word per clock: all work for a word is done
// between the input handshake and a single result register, so a result
// appears in the cycle after acceptance and the next word is taken in the same
// cycle that the previous result leaves. The only thing that holds the input
// is a full result register that the output side does not take.
module oil_dose_scheduler #(
  parameter int unsigned SAMPLES_PER_READING = ods_pkg::SAMPLES_PER_READING_DEF,
  parameter int unsigned ADC_BITS            = ods_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ods_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ods_pkg::CFG_W-1:0]     cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ADC_BITS-1:0]           adc_sample_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          atomizer_on_o,
  output logic [ods_pkg::LEVEL_W-1:0]   oil_level_o,
  output logic                          oil_low_alert_o,
  output logic [ods_pkg::DOSE_W-1:0]    dose_count_o,
  output logic                          level_updated_o
);

  localparam int unsigned IdxW  = $clog2(SAMPLES_PER_READING + 1);
  localparam int unsigned SumW  = ADC_BITS + $clog2(SAMPLES_PER_READING + 1);
  localparam int unsigned LvlW  = ods_pkg::LEVEL_W;
  localparam int unsigned DoseW = ods_pkg::DOSE_W;
  localparam int unsigned TimW  = ods_pkg::TIMER_W;

  typedef enum logic [1:0] {
    PH_MEASURE = 2'd0,
    PH_DOSE    = 2'd1,
    PH_WAIT    = 2'd2
  } phase_e;

  // configuration registers
  logic [15:0]     dose_ticks_q;
  logic [31:0]     interval_ticks_q;
  logic [LvlW-1:0] low_threshold_q;
  logic [LvlW-1:0] empty_threshold_q;

  // sequencer state
  phase_e           phase_q, phase_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [TimW-1:0]  timer_q, timer_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             alert_q, alert_d;
  logic [DoseW-1:0] dose_q, dose_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             atom_q, atom_d;
  logic             updated_q, updated_d;

  logic                in_accept;
  logic                timer_done;
  logic [SumW-1:0]     sum_next;
  logic [IdxW-1:0]     idx_next;
  ods_pkg::level_res_t lvl_res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign sum_next   = sum_q + SumW'(adc_sample_i);
  assign idx_next   = idx_q + IdxW'(1);
  assign timer_done = timer_q <= TimW'(1);

  // level mapping of the sum that includes this sample
  ods_level #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SUM_W               (SumW)
  ) u_level (
    .sum_i             (sum_next),
    .low_threshold_i   (low_threshold_q),
    .empty_threshold_i (empty_threshold_q),
    .res_o             (lvl_res)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dose_ticks_q      <= ods_pkg::DOSE_TICKS_RST;
      interval_ticks_q  <= ods_pkg::INTERVAL_TICKS_RST;
      low_threshold_q   <= ods_pkg::LOW_THRESHOLD_RST;
      empty_threshold_q <= ods_pkg::EMPTY_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (ods_pkg::cfg_reg_e'(cfg_idx_i))
        ods_pkg::CFG_DOSE_TICKS:      dose_ticks_q      <= cfg_data_i[15:0];
        ods_pkg::CFG_INTERVAL_TICKS:  interval_ticks_q  <= cfg_data_i[31:0];
        ods_pkg::CFG_LOW_THRESHOLD:   low_threshold_q   <= cfg_data_i[LvlW-1:0];
        ods_pkg::CFG_EMPTY_THRESHOLD: empty_threshold_q <= cfg_data_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  // next state and next result word
  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    timer_d     = timer_q;
    level_d     = level_q;
    alert_d     = alert_q;
    dose_d      = dose_q;
    updated_d   = updated_q;
    atom_d      = atom_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (in_accept) begin
      updated_d = 1'b0;
      if (!req_type_i) begin
        // sample: only counted while measuring
        if (phase_q == PH_MEASURE) begin
          if (idx_next >= IdxW'(SAMPLES_PER_READING)) begin
            level_d   = lvl_res.level;
            alert_d   = lvl_res.alert;
            sum_d     = '0;
            idx_d     = '0;
            updated_d = 1'b1;
            if (lvl_res.skip) begin
              phase_d = PH_WAIT;
              timer_d = interval_ticks_q;
            end else begin
              phase_d = PH_DOSE;
              timer_d = TimW'(dose_ticks_q);
            end
          end else begin
            sum_d = sum_next;
            idx_d = idx_next;
          end
        end
      end else begin
        // tick: counts down the dose and wait phases
        case (phase_q)
          PH_DOSE: begin
            if (timer_done) begin
              dose_d  = dose_q + DoseW'(1);
              phase_d = PH_WAIT;
              timer_d = interval_ticks_q;
            end else begin
              timer_d = timer_q - TimW'(1);
            end
          end
          PH_WAIT: begin
            if (timer_done) begin
              timer_d = '0;
              phase_d = PH_MEASURE;
              idx_d   = '0;
              sum_d   = '0;
            end else begin
              timer_d = timer_q - TimW'(1);
            end
          end
          default: ;
        endcase
      end
      atom_d      = phase_d == PH_DOSE;
      out_valid_d = 1'b1;
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MEASURE;
      idx_q       <= '0;
      sum_q       <= '0;
      timer_q     <= '0;
      level_q     <= '0;
      alert_q     <= 1'b0;
      dose_q      <= '0;
      out_valid_q <= 1'b0;
      atom_q      <= 1'b0;
      updated_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      timer_q     <= timer_d;
      level_q     <= level_d;
      alert_q     <= alert_d;
      dose_q      <= dose_d;
      out_valid_q <= out_valid_d;
      atom_q      <= atom_d;
      updated_q   <= updated_d;
    end
  end

  // result word
  assign out_valid_o     = out_valid_q;
  assign atomizer_on_o   = atom_q;
  assign oil_level_o     = level_q;
  assign oil_low_alert_o = alert_q;
  assign dose_count_o    = dose_q;
  assign level_updated_o = updated_q;

endmodule

// File: hw/rtl/ods_checker.sv
// ----------------------------------------------------------------------------
// ods_checker
// port-level checks of the oil dose scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "oil_dose_scheduler_defines.svh"

module ods_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        atomizer_on_o,
  input logic [ods_pkg::LEVEL_W-1:0] oil_level_o,
  input logic [ods_pkg::DOSE_W-1:0]  dose_count_o,
  input logic                        level_updated_o
);

  localparam logic [ods_pkg::LEVEL_W-1:0] FullPct = ods_pkg::LEVEL_W'(ods_pkg::LVL_FULL_PCT);
  localparam logic [ods_pkg::DOSE_W-1:0]  DoseOne = ods_pkg::DOSE_W'(1);

  // a pending word is not dropped
  `ODS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result word dropped")

  // level never beyond full scale
  `ODS_ASSERT_NOW(a_level_range, out_valid_o, oil_level_o <= FullPct, "oil level above full scale")

  // dose count moves by at most one per word
  `ODS_ASSERT_NEXT(a_dose_step, 1'b1, dose_count_o == $past(dose_count_o) || dose_count_o == $past(dose_count_o) + DoseOne, "dose count jumped")

  // a finished dose leaves the atomizer off
  `ODS_ASSERT_NOW(a_dose_end_off, !$stable(dose_count_o), !atomizer_on_o, "atomizer on after dose end")

  // level only changes on a word that completed a reading
  `ODS_ASSERT_NOW(a_level_update, !$stable(oil_level_o), level_updated_o, "level changed without update")

endmodule

bind oil_dose_scheduler ods_checker u_ods_checker (.*);
